>>> hw/rtl/cds_pkg.sv
// shared types, constants and calendar helpers for the date stepper
package cds_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_CHECK,
        S_STEP,
        S_DONE
    } t_state;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_RETREAT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LOAD = 2'd1;
    localparam logic [1:0] ST_OVER     = 2'd2;
    localparam logic [1:0] ST_UNDER    = 2'd3;

    localparam int          CYCLE_YEARS = 400;
    localparam int          CENTURY     = 100;
    localparam int          YEAR_RESET  = 1900;
    localparam logic [8:0]  YMOD_RESET  = 9'(YEAR_RESET % CYCLE_YEARS);
    localparam logic [8:0]  YMOD_LAST   = 9'(CYCLE_YEARS - 1);
    localparam logic [4:0]  FEB_LEAP    = 5'd29;
    localparam logic [4:0]  DAY_MAX     = 5'd31;
    localparam logic [3:0]  MONTH_FEB   = 4'd2;
    localparam logic [3:0]  MONTH_LAST  = 4'd12;

    // floor(x / 25) is (x * RECIP_25) >> RECIP_SHIFT for x below 2^28
    localparam int          RECIP_SHIFT = 33;
    localparam logic [28:0] RECIP_25    = 29'h147AE148;

    localparam logic [4:0] MONTH_LEN [13] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // leap test from the year taken modulo 400
    function automatic logic is_leap(input logic [8:0] ymod);
        logic cent;
        cent = (ymod == 9'(CENTURY)) || (ymod == 9'(2 * CENTURY)) ||
               (ymod == 9'(3 * CENTURY));
        return (ymod[1:0] == 2'd0) && !cent;
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month < 4'd1 || month > MONTH_LAST) begin
            len = DAY_MAX;
        end else if (month == MONTH_FEB && leap) begin
            len = FEB_LEAP;
        end else begin
            len = MONTH_LEN[month];
        end
        return len;
    endfunction

endpackage

>>> hw/rtl/cds_if.sv
// command and result channel interfaces
interface cds_cmd_if #(
    parameter int YEAR_BITS  = 16,
    parameter int COUNT_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            command;
    logic [4:0]            day_in;
    logic [3:0]            month_in;
    logic [YEAR_BITS-1:0]  year_in;
    logic [COUNT_BITS-1:0] step_count;

    modport source (output valid, command, day_in, month_in, year_in, step_count,
                    input ready);
    modport sink   (input valid, command, day_in, month_in, year_in, step_count,
                    output ready);
endinterface

interface cds_res_if #(
    parameter int YEAR_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [4:0]           day_out;
    logic [3:0]           month_out;
    logic [YEAR_BITS-1:0] year_out;
    logic [1:0]           status;

    modport source (output valid, day_out, month_out, year_out, status, input ready);
    modport sink   (input valid, day_out, month_out, year_out, status, output ready);
endinterface

>>> hw/rtl/calendar_date_stepper_top.sv
// gregorian date register with load, advance and retreat commands
//
// i_cmd carries one command beat: load (day_in, month_in, year_in), advance or
// retreat by step_count days. o_res returns one beat per command: the date
// after the command and a status (ok, bad load, overflow, underflow).
// i_cmd.ready is high only when the sequencer is idle and the result register
// is empty or being drained in the same cycle.
// load steps through a reciprocal multiply for the year mod 400, a remainder
// step, a check step and a result step.
// advance/retreat walk the date month by month: a single
// subtract/compare unit takes the remaining count across one month boundary
// per cycle, and the walk ends in the result step.
// an unused command code goes straight to the result step.
// reset (synchronous, active low) sets the date to 1 January 1900 and empties
// the result register.
// a stalled receiver holds the result beat; the next command waits until it
// drains.
module calendar_date_stepper_top #(
    parameter int YEAR_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cds_cmd_if.sink   i_cmd,
    cds_res_if.source o_res
);
    import cds_pkg::*;

    localparam int CW    = (COUNT_BITS > 5) ? COUNT_BITS : 5;
    localparam int QX_W  = YEAR_BITS - 4;
    localparam int PW    = QX_W + 29;
    localparam int QW    = YEAR_BITS - 8;

    t_state                r_state, n_state;
    logic [1:0]            r_cmd, n_cmd;
    logic [4:0]            r_d, n_d;
    logic [3:0]            r_m, n_m;
    logic [YEAR_BITS-1:0]  r_y, n_y;
    logic [QW-1:0]         r_q, n_q;
    logic                  r_phase, n_phase;
    logic [8:0]            r_rem, n_rem;
    logic [COUNT_BITS-1:0] r_n, n_n;
    logic [4:0]            r_day, n_day;
    logic [3:0]            r_month, n_month;
    logic [YEAR_BITS-1:0]  r_year, n_year;
    logic [8:0]            r_ymod, n_ymod;
    logic [1:0]            r_status, n_status;
    logic                  r_ovalid, n_ovalid;
    logic [4:0]            r_o_day, n_o_day;
    logic [3:0]            r_o_month, n_o_month;
    logic [YEAR_BITS-1:0]  r_o_year, n_o_year;
    logic [1:0]            r_o_status, n_o_status;

    logic                  in_take;
    logic                  fwd;
    logic [4:0]            dim;
    logic [4:0]            left_p1;
    logic [4:0]            step_b;
    logic [CW-1:0]         n_ext;
    logic [CW-1:0]         b_ext;
    logic [CW-1:0]         diff;
    logic                  fits;
    logic [PW-1:0]         prod;
    logic [8:0]            rem_ld;
    logic                  ld_ok;
    logic [3:0]            mon_dn;
    logic [YEAR_BITS-1:0]  year_dn;
    logic [8:0]            ymod_dn;

    assign i_cmd.ready     = (r_state == S_IDLE) && (!r_ovalid || o_res.ready);
    assign in_take         = i_cmd.valid && i_cmd.ready;
    assign o_res.valid     = r_ovalid;
    assign o_res.day_out   = r_o_day;
    assign o_res.month_out = r_o_month;
    assign o_res.year_out  = r_o_year;
    assign o_res.status    = r_o_status;

    // shared compare-subtract unit
    assign fwd     = (r_cmd == CMD_ADVANCE);
    assign dim     = days_in(r_month, is_leap(r_ymod));
    assign left_p1 = 5'(6'(dim) - 6'(r_day) + 6'd1);
    assign step_b  = fwd ? left_p1 : r_day;
    assign n_ext   = CW'(r_n);
    assign b_ext   = CW'(step_b);
    assign diff    = n_ext - b_ext;
    assign fits    = n_ext < b_ext;

    // year mod 400 by reciprocal multiply
    assign prod    = PW'(r_y[YEAR_BITS-1:4]) * PW'(RECIP_25);
    assign rem_ld  = 9'(r_y - YEAR_BITS'(r_q) * YEAR_BITS'(CYCLE_YEARS));

    assign ld_ok = (r_y != '0) && (r_m >= 4'd1) && (r_m <= MONTH_LAST) &&
                   (r_d >= 5'd1) && (r_d <= days_in(r_m, is_leap(r_rem)));

    assign mon_dn  = (r_month == 4'd1) ? MONTH_LAST : (r_month - 4'd1);
    assign year_dn = (r_month == 4'd1) ? (r_year - YEAR_BITS'(1)) : r_year;
    assign ymod_dn = (r_month != 4'd1) ? r_ymod :
                     ((r_ymod == 9'd0) ? YMOD_LAST : (r_ymod - 9'd1));

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_d        = r_d;
        n_m        = r_m;
        n_y        = r_y;
        n_q        = r_q;
        n_phase    = r_phase;
        n_rem      = r_rem;
        n_n        = r_n;
        n_day      = r_day;
        n_month    = r_month;
        n_year     = r_year;
        n_ymod     = r_ymod;
        n_status   = r_status;
        n_ovalid   = r_ovalid && !o_res.ready;
        n_o_day    = r_o_day;
        n_o_month  = r_o_month;
        n_o_year   = r_o_year;
        n_o_status = r_o_status;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_cmd    = i_cmd.command;
                    n_d      = i_cmd.day_in;
                    n_m      = i_cmd.month_in;
                    n_y      = i_cmd.year_in;
                    n_n      = i_cmd.step_count;
                    n_phase  = 1'b1;
                    n_status = ST_OK;
                    if (i_cmd.command == CMD_LOAD) begin
                        n_state = S_MOD;
                    end else if (i_cmd.command == CMD_ADVANCE ||
                                 i_cmd.command == CMD_RETREAT) begin
                        n_state = S_STEP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MOD: begin
                if (r_phase) begin
                    n_q     = prod[PW-1:RECIP_SHIFT];
                    n_phase = 1'b0;
                end else begin
                    n_rem   = rem_ld;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (ld_ok) begin
                    n_day    = r_d;
                    n_month  = r_m;
                    n_year   = r_y;
                    n_ymod   = r_rem;
                    n_status = ST_OK;
                end else begin
                    n_status = ST_BAD_LOAD;
                end
                n_state = S_DONE;
            end
            S_STEP: begin
                if (fits) begin
                    n_day   = fwd ? (r_day + 5'(n_ext)) : (r_day - 5'(n_ext));
                    n_state = S_DONE;
                end else if (fwd) begin
                    if (r_month == MONTH_LAST && (&r_year)) begin
                        n_day    = DAY_MAX;
                        n_status = ST_OVER;
                        n_state  = S_DONE;
                    end else begin
                        n_n   = COUNT_BITS'(diff);
                        n_day = 5'd1;
                        if (r_month == MONTH_LAST) begin
                            n_month = 4'd1;
                            n_year  = r_year + YEAR_BITS'(1);
                            n_ymod  = (r_ymod == YMOD_LAST) ? 9'd0 : (r_ymod + 9'd1);
                        end else begin
                            n_month = r_month + 4'd1;
                        end
                    end
                end else begin
                    if (r_month == 4'd1 && r_year <= YEAR_BITS'(1)) begin
                        n_day    = 5'd1;
                        n_status = ST_UNDER;
                        n_state  = S_DONE;
                    end else begin
                        n_n     = COUNT_BITS'(diff);
                        n_month = mon_dn;
                        n_year  = year_dn;
                        n_ymod  = ymod_dn;
                        n_day   = days_in(mon_dn, is_leap(ymod_dn));
                    end
                end
            end
            S_DONE: begin
                n_ovalid   = 1'b1;
                n_o_day    = r_day;
                n_o_month  = r_month;
                n_o_year   = r_year;
                n_o_status = r_status;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_day    <= 5'd1;
            r_month  <= 4'd1;
            r_year   <= YEAR_BITS'(YEAR_RESET);
            r_ymod   <= YMOD_RESET;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_day    <= n_day;
            r_month  <= n_month;
            r_year   <= n_year;
            r_ymod   <= n_ymod;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_d        <= n_d;
        r_m        <= n_m;
        r_y        <= n_y;
        r_q        <= n_q;
        r_phase    <= n_phase;
        r_rem      <= n_rem;
        r_n        <= n_n;
        r_o_day    <= n_o_day;
        r_o_month  <= n_o_month;
        r_o_year   <= n_o_year;
        r_o_status <= n_o_status;
    end

    // held date is always a real calendar date
    a_date_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_month >= 4'd1) && (r_month <= MONTH_LAST) && (r_day >= 5'd1) &&
        (r_day <= days_in(r_month, is_leap(r_ymod))) && (r_year != '0))
        else $error("held date out of range");

    // year residue stays below the 400-year cycle
    a_ymod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ymod < 9'(CYCLE_YEARS))
        else $error("year residue out of range");

    // an accepted beat always starts work
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state != S_IDLE))
        else $error("accepted command left sequencer idle");

    // underflow result is pinned to the first day of year one
    a_under_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_status == ST_UNDER) |->
        (r_o_day == 5'd1 && r_o_month == 4'd1 && r_o_year == YEAR_BITS'(1)))
        else $error("underflow result not saturated");

endmodule
